// ===== rtl/tre_pkg.sv =====
// shared types and constants of the row run-length encoder
package tre_pkg;

  localparam int MAX_PACKET_DEF = 128;   // largest packet in pixels
  localparam int PIX_W          = 8;
  localparam int PLEN_W         = 8;     // packet length field, covers up to 128 pixels
  localparam int WORD_BYTES     = 8;
  localparam int WORD_W         = 64;
  localparam int OCNT_W         = 4;
  localparam int OUT_TDATA_W    = 72;    // data and byte count, padded to whole bytes

  localparam logic [7:0] RUN_DESC      = 8'h80;
  localparam logic [7:0] DESC_CNT_MASK = 8'h7f;

  typedef enum logic [1:0] {
    PK_NONE,
    PK_RAW,
    PK_RUN
  } pkt_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR2,
    ST_EMIT
  } ctrl_state_t;

  // up to two packets closed by one pixel, in output order
  typedef struct packed {
    pkt_kind_t         a_kind;
    logic [PLEN_W-1:0] a_len;
    pkt_kind_t         b_kind;
    logic [PLEN_W-1:0] b_len;
    logic [PIX_W-1:0]  val;       // run value
    logic              row_end;
  } plan_t;

endpackage

// ===== rtl/tre_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module tre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tre_ctrl.sv =====
// packet decision logic: pixel state, store writes and packet plan per pixel
module tre_ctrl #(
  parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tre_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_last,
  output logic                          wr_en,
  output logic [$clog2(MAX_PACKET)-1:0] wr_addr,
  output logic [tre_pkg::PIX_W-1:0]     wr_data,
  output tre_pkg::plan_t                plan,
  output logic                          start,
  input  logic                          pk_busy
);

  import tre_pkg::*;

  localparam int LEN_W = $clog2(MAX_PACKET + 1);
  localparam int AW    = $clog2(MAX_PACKET);
  localparam logic [LEN_W:0] MAX_C = (LEN_W + 1)'(MAX_PACKET);
  localparam logic PAIR_FILLS = (MAX_PACKET <= 2);

  ctrl_state_t        state_r, state_nxt;
  logic [PIX_W-1:0]   held_r, held_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               have_r, have_nxt;
  logic               run_r, run_nxt;
  plan_t              plan_r, plan_nxt;
  logic               start_r, start_nxt;
  logic [AW-1:0]      wr2_addr_r, wr2_addr_nxt;
  logic [PIX_W-1:0]   wr2_data_r, wr2_data_nxt;

  logic               accept;
  logic               eq;
  logic               emit;
  logic               need_wr2;
  logic [LEN_W:0]     len_p1;
  logic [LEN_W:0]     len_p2;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign eq     = (in_pixel == held_r);
  assign len_p1 = {1'b0, len_r} + (LEN_W + 1)'(1);
  assign len_p2 = {1'b0, len_r} + (LEN_W + 1)'(2);

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    len_nxt      = len_r;
    have_nxt     = have_r;
    run_nxt      = run_r;
    plan_nxt     = plan_r;
    start_nxt    = 1'b0;
    wr2_addr_nxt = wr2_addr_r;
    wr2_data_nxt = wr2_data_r;
    wr_en        = 1'b0;
    wr_addr      = len_r[AW-1:0];
    wr_data      = held_r;
    emit         = 1'b0;
    need_wr2     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          plan_nxt.a_kind  = PK_NONE;
          plan_nxt.a_len   = PLEN_W'(1);
          plan_nxt.b_kind  = PK_NONE;
          plan_nxt.b_len   = PLEN_W'(1);
          plan_nxt.val     = held_r;
          plan_nxt.row_end = in_last;

          if (!have_r) begin
            if (in_last) begin
              // lone pixel at row end
              wr_en           = 1'b1;
              wr_addr         = '0;
              wr_data         = in_pixel;
              plan_nxt.a_kind = PK_RAW;
              emit            = 1'b1;
            end else begin
              held_nxt = in_pixel;
              have_nxt = 1'b1;
              run_nxt  = 1'b0;
              len_nxt  = '0;
            end
          end else if (run_r) begin
            if (eq) begin
              if (len_p1 >= MAX_C || in_last) begin
                plan_nxt.a_kind = PK_RUN;
                plan_nxt.a_len  = PLEN_W'(len_p1);
                emit            = 1'b1;
                have_nxt        = 1'b0;
                run_nxt         = 1'b0;
                len_nxt         = '0;
              end else begin
                len_nxt = LEN_W'(len_p1);
              end
            end else begin
              plan_nxt.a_kind = PK_RUN;
              plan_nxt.a_len  = PLEN_W'(len_r);
              emit            = 1'b1;
              if (in_last) begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data         = in_pixel;
                plan_nxt.b_kind = PK_RAW;
                have_nxt        = 1'b0;
                run_nxt         = 1'b0;
                len_nxt         = '0;
              end else begin
                held_nxt = in_pixel;
                have_nxt = 1'b1;
                run_nxt  = 1'b0;
                len_nxt  = '0;
              end
            end
          end else if (eq) begin
            // equal pair closes the open raw packet and opens a run
            if (len_r != '0) begin
              plan_nxt.a_kind = PK_RAW;
              plan_nxt.a_len  = PLEN_W'(len_r);
              emit            = 1'b1;
            end
            run_nxt = 1'b1;
            len_nxt = LEN_W'(2);
            if (PAIR_FILLS || in_last) begin
              if (len_r != '0) begin
                plan_nxt.b_kind = PK_RUN;
                plan_nxt.b_len  = PLEN_W'(2);
              end else begin
                plan_nxt.a_kind = PK_RUN;
                plan_nxt.a_len  = PLEN_W'(2);
              end
              emit     = 1'b1;
              have_nxt = 1'b0;
              run_nxt  = 1'b0;
              len_nxt  = '0;
            end
          end else begin
            wr_en = 1'b1;
            if (len_p2 >= MAX_C || in_last) begin
              plan_nxt.a_kind = PK_RAW;
              plan_nxt.a_len  = PLEN_W'(len_p2);
              emit            = 1'b1;
              need_wr2        = 1'b1;
              wr2_addr_nxt    = len_p1[AW-1:0];
              wr2_data_nxt    = in_pixel;
              have_nxt        = 1'b0;
              run_nxt         = 1'b0;
              len_nxt         = '0;
            end else begin
              len_nxt  = LEN_W'(len_p1);
              held_nxt = in_pixel;
            end
          end

          if (emit) begin
            state_nxt = need_wr2 ? ST_WR2 : ST_EMIT;
            start_nxt = !need_wr2;
          end
        end
      end

      ST_WR2: begin
        // the pixel that closes a raw packet goes in behind the held one
        wr_en     = 1'b1;
        wr_addr   = wr2_addr_r;
        wr_data   = wr2_data_r;
        state_nxt = ST_EMIT;
        start_nxt = 1'b1;
      end

      ST_EMIT: begin
        if (!start_r && !pk_busy) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      len_r   <= '0;
      have_r  <= 1'b0;
      run_r   <= 1'b0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      have_r  <= have_nxt;
      run_r   <= run_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r     <= plan_nxt;
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign plan     = plan_r;
  assign start    = start_r;

  a_raw_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && !run_r) |-> (len_p2 <= MAX_C))
    else $error("open raw packet longer than allowed");

  a_run_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (have_r && ({1'b0, len_r} < MAX_C) && (len_r >= LEN_W'(2))))
    else $error("open run count out of range");

  a_start_has_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (plan_r.a_kind != PK_NONE))
    else $error("packer started with an empty plan");

  a_wr2_then_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR2) |=> start_r)
    else $error("second store write not followed by packer start");

endmodule

// ===== rtl/tre_packer.sv =====
// packet byte sequencer: reads raw pixels from the store and packs 8-byte words
module tre_packer #(
  parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  tre_pkg::plan_t                plan,
  output logic                          busy,
  output logic                          rd_en,
  output logic [$clog2(MAX_PACKET)-1:0] rd_addr,
  input  logic [tre_pkg::PIX_W-1:0]     rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tre_pkg::WORD_W-1:0]    out_data,
  output logic [tre_pkg::OCNT_W-1:0]    out_count,
  output logic                          out_row_done,
  output logic                          out_last_step
);

  import tre_pkg::*;

  localparam int AW = $clog2(MAX_PACKET);
  localparam int WC_W = $clog2(WORD_BYTES);

  logic              busy_r;
  pkt_kind_t         cur_kind_r;
  logic [PLEN_W-1:0] cur_len_r;
  pkt_kind_t         nxt_kind_r;
  logic [PLEN_W-1:0] nxt_len_r;
  logic [PIX_W-1:0]  val_r;
  logic              row_end_r;
  logic [PLEN_W-1:0] pos_r;         // 0 is the descriptor, then pixel bytes
  logic [WORD_W-1:0] wbuf_r;
  logic [WC_W-1:0]   wcnt_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;
  logic [OCNT_W-1:0] out_count_r;
  logic              out_row_done_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  desc_byte;
  logic [PIX_W-1:0]  byte_v;
  logic [WORD_W-1:0] word_nxt;
  logic              pkt_end;
  logic              step_end;
  logic              word_done;
  logic              out_free;
  logic              put;

  always_comb begin
    desc_byte = ((cur_len_r - PLEN_W'(1)) & DESC_CNT_MASK)
              | ((cur_kind_r == PK_RUN) ? RUN_DESC : '0);
    if (pos_r == '0) begin
      byte_v = desc_byte;
    end else if (cur_kind_r == PK_RUN) begin
      byte_v = val_r;
    end else begin
      byte_v = rd_data;
    end
  end

  assign pkt_end   = (cur_kind_r == PK_RUN) ? (pos_r == PLEN_W'(1)) : (pos_r == cur_len_r);
  assign step_end  = pkt_end && (nxt_kind_r == PK_NONE);
  assign word_done = (wcnt_r == WC_W'(WORD_BYTES - 1)) || pkt_end;
  assign out_free  = !out_valid_r || out_ready;
  // a byte that closes a word moves only when the output register frees up
  assign put       = busy_r && (!word_done || out_free);
  assign word_nxt  = wbuf_r | (WORD_W'(byte_v) << {wcnt_r, 3'b000});

  // prefetch the next raw pixel in step with the byte that goes out now
  assign rd_en   = put && (cur_kind_r == PK_RAW) && (pos_r < cur_len_r);
  assign rd_addr = pos_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      wcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        wcnt_r <= '0;
      end else if (put) begin
        wcnt_r <= word_done ? '0 : wcnt_r + WC_W'(1);
        if (step_end) begin
          busy_r <= 1'b0;
        end
      end
      if (put && word_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_kind_r <= plan.a_kind;
      cur_len_r  <= plan.a_len;
      nxt_kind_r <= plan.b_kind;
      nxt_len_r  <= plan.b_len;
      val_r      <= plan.val;
      row_end_r  <= plan.row_end;
      pos_r      <= '0;
      wbuf_r     <= '0;
    end else if (put) begin
      wbuf_r <= word_done ? '0 : word_nxt;
      if (pkt_end) begin
        cur_kind_r <= nxt_kind_r;
        cur_len_r  <= nxt_len_r;
        nxt_kind_r <= PK_NONE;
        pos_r      <= '0;
      end else begin
        pos_r <= pos_r + PLEN_W'(1);
      end
    end
    if (put && word_done) begin
      out_data_r     <= word_nxt;
      out_count_r    <= {1'b0, wcnt_r} + OCNT_W'(1);
      out_row_done_r <= step_end && row_end_r;
      out_last_r     <= step_end;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_count     = out_count_r;
  assign out_row_done  = out_row_done_r;
  assign out_last_step = out_last_r;

  a_idle_word_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (wcnt_r == '0))
    else $error("partial word left over after a step");

  a_raw_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur_kind_r == PK_RAW) |-> (pos_r <= cur_len_r))
    else $error("raw byte position past packet end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_count_r)
                                     && $stable(out_last_r)))
    else $error("pending result overwritten");

endmodule

// ===== rtl/tga_rle_row_encoder_core.sv =====
// top level of the row run-length encoder: decision logic, pixel store and word packer
//
//  channel | side   | tdata                          | tlast        | tuser
//  in_     | slave  | [7:0] pixel                    | last_in_row  | -
//  out_    | master | [63:0] out_data, [67:64] count | row_done     | [0] last_of_step
//
// a pixel that closes no packet leaves the control idle, so in_tready stays high
// a pixel that closes packets moves the control to ST_EMIT (by way of ST_WR2 when the
// closing pixel needs a second store write) and starts the packer, which sends one
// encoded byte (descriptor and pixels) per cycle while out_ does not stall; the rate is
// set by the byte-wide store read port; synchronous active-low reset clears all control
// state; the pixel store is not cleared, only entries written for the open packet
// are ever read; a stalled out_ holds the packer at the word that is waiting; a
// finished step's last word may still wait while the next pixel is taken in
module tga_rle_row_encoder_core #(
  parameter int MAX_PACKET = tre_pkg::MAX_PACKET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tre_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel
  input  logic                            in_tlast,   // last_in_row
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tre_pkg::OUT_TDATA_W-1:0] out_tdata,  // [63:0] out_data, [67:64] out_count
  output logic                            out_tlast,  // row_done
  output logic [0:0]                      out_tuser   // [0] last_of_step
);

  import tre_pkg::*;

  localparam int AW = $clog2(MAX_PACKET);

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [PIX_W-1:0]   wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [PIX_W-1:0]   rd_data;
  plan_t              plan;
  logic               start;
  logic               pk_busy;
  logic [WORD_W-1:0]  out_data;
  logic [OCNT_W-1:0]  out_count;
  logic               row_done;
  logic               last_step;

  tre_ctrl #(
    .MAX_PACKET(MAX_PACKET)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .in_last  (in_tlast),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .plan     (plan),
    .start    (start),
    .pk_busy  (pk_busy)
  );

  tre_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_PACKET)
  ) u_raw_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tre_packer #(
    .MAX_PACKET(MAX_PACKET)
  ) u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .plan          (plan),
    .busy          (pk_busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_data),
    .out_count     (out_count),
    .out_row_done  (row_done),
    .out_last_step (last_step)
  );

  assign out_tdata = {(OUT_TDATA_W - WORD_W - OCNT_W)'(0), out_count, out_data};
  assign out_tlast = row_done;
  assign out_tuser = last_step;

endmodule
